@@ design/sacl_pkg.sv @@
// shared types and constants for the set associative cache lookup
package sacl_pkg;

    // address width of the access port
    localparam int ADDR_BITS = 32;

    // default geometry
    localparam int DEF_NUM_SETS    = 8;
    localparam int DEF_NUM_WAYS    = 4;
    localparam int DEF_OFFSET_BITS = 5;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_DONE
    } seq_state_t;

endpackage

@@ design/sacl_store.sv @@
// tag and metadata memories, one shared address, registered read data
module sacl_store
    import sacl_pkg::*;
#(
    parameter int ENTRIES = DEF_NUM_SETS * DEF_NUM_WAYS,
    parameter int TAG_W   = ADDR_BITS - DEF_OFFSET_BITS - $clog2(DEF_NUM_SETS),
    parameter int META_W  = 1 + $clog2(DEF_NUM_WAYS)
)
(
    input  logic                       clk,
    input  logic [$clog2(ENTRIES)-1:0] addr,
    input  logic                       tag_we,
    input  logic                       meta_we,
    input  logic [TAG_W-1:0]           wr_tag,
    input  logic [META_W-1:0]          wr_meta,
    output logic [TAG_W-1:0]           rd_tag,
    output logic [META_W-1:0]          rd_meta
);

    logic [TAG_W-1:0]  tag_mem [ENTRIES];
    logic [META_W-1:0] meta_mem [ENTRIES];
    logic [TAG_W-1:0]  rd_tag_reg;
    logic [META_W-1:0] rd_meta_reg;

    // tag memory, no reset
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[addr] <= wr_tag;
        end
        rd_tag_reg <= tag_mem[addr];
    end

    // valid bit and lru rank per entry, initialized by the clearing pass
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[addr] <= wr_meta;
        end
        rd_meta_reg <= meta_mem[addr];
    end

    assign rd_tag  = rd_tag_reg;
    assign rd_meta = rd_meta_reg;

endmodule

@@ design/sacl_way_unit.sv @@
// shared way evaluator: tag match and victim rank compare for one way
module sacl_way_unit
    import sacl_pkg::*;
#(
    parameter int TAG_W = ADDR_BITS - DEF_OFFSET_BITS - $clog2(DEF_NUM_SETS),
    parameter int WAY_W = $clog2(DEF_NUM_WAYS)
)
(
    input  logic [TAG_W-1:0] tag_ref,
    input  logic [TAG_W-1:0] tag_rd,
    input  logic             rd_valid,
    input  logic [WAY_W-1:0] rd_rank,
    input  logic [WAY_W-1:0] rd_way,
    input  logic             hit_in,
    input  logic [WAY_W-1:0] hit_way_in,
    input  logic [WAY_W-1:0] vic_way_in,
    input  logic [WAY_W-1:0] vic_rank_in,
    output logic             hit_out,
    output logic [WAY_W-1:0] hit_way_out,
    output logic [WAY_W-1:0] vic_way_out,
    output logic [WAY_W-1:0] vic_rank_out
);

    logic match;
    logic take;

    // first valid match wins, lower ways are seen first
    assign match       = rd_valid && (tag_rd == tag_ref);
    assign hit_out     = hit_in || match;
    assign hit_way_out = (!hit_in && match) ? rd_way : hit_way_in;

    // highest rank wins, ties stay with the lower way
    assign take         = (rd_way == '0) || (rd_rank > vic_rank_in);
    assign vic_way_out  = take ? rd_way : vic_way_in;
    assign vic_rank_out = take ? rd_rank : vic_rank_in;

endmodule

@@ design/set_assoc_cache_lru_lookup.sv @@
// set associative cache lookup with true lru, one way examined per cycle
// sequence: scan of the set, drain, rank update, done; when NUM_SETS is not a power of
//   two, a bit serial remainder over the ADDR_BITS-OFFSET_BITS address bits comes first
// a new item is not taken until the result has left the done state; the single memory
//   port serves NUM_WAYS reads to scan the set and NUM_WAYS writes to update ranks
// reset: a clearing pass over all NUM_SETS*NUM_WAYS entries rewrites valid
//   bits and ranks; no item is taken until it ends
module set_assoc_cache_lru_lookup
    import sacl_pkg::*;
#(
    parameter int NUM_SETS    = DEF_NUM_SETS,
    parameter int NUM_WAYS    = DEF_NUM_WAYS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ADDR_BITS-1:0]        address,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        hit,
    output logic [$clog2(NUM_WAYS)-1:0] way
);

    localparam int  SET_W     = $clog2(NUM_SETS);
    localparam int  WAY_W     = $clog2(NUM_WAYS);
    localparam int  ENTRIES   = NUM_SETS * NUM_WAYS;
    localparam int  ENT_W     = $clog2(ENTRIES);
    localparam int  TAG_W     = ADDR_BITS - OFFSET_BITS - SET_W;
    localparam int  QB        = ADDR_BITS - OFFSET_BITS;
    localparam int  QCNT_W    = $clog2(QB);
    localparam int  META_W    = 1 + WAY_W;
    localparam bit  SETS_POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);

    seq_state_t          state_reg, state_next;
    logic [SET_W-1:0]    set_reg, set_next;
    logic [WAY_W-1:0]    way_cnt_reg, way_cnt_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [SET_W-1:0]    rem_reg, rem_next;
    logic [QB-1:0]       div_reg, div_next;
    logic [QCNT_W-1:0]   mod_cnt_reg, mod_cnt_next;
    logic                rdv_reg, rdv_next;
    logic [WAY_W-1:0]    rdw_reg, rdw_next;
    logic                hit_acc_reg, hit_acc_next;
    logic [WAY_W-1:0]    hit_way_reg, hit_way_next;
    logic [WAY_W-1:0]    vic_way_reg, vic_way_next;
    logic [WAY_W-1:0]    vic_rank_reg, vic_rank_next;
    logic [WAY_W-1:0]    rank_reg [NUM_WAYS];
    logic                valid_reg [NUM_WAYS];
    logic                out_valid_reg, out_valid_next;
    logic                hit_reg, hit_next;
    logic [WAY_W-1:0]    way_reg, way_next;

    logic [ENT_W-1:0]    ent_addr;
    logic                tag_we, meta_we;
    logic [META_W-1:0]   wr_meta;
    logic [TAG_W-1:0]    rd_tag;
    logic [META_W-1:0]   rd_meta;
    logic                u_hit;
    logic [WAY_W-1:0]    u_hit_way, u_vic_way, u_vic_rank;
    logic                in_acc;
    logic                out_free;
    logic                last_way;
    logic [SET_W:0]      trial;
    logic [WAY_W-1:0]    acc_way, old_rank, cur_rank, new_rank;

    // entry address of the current way in the current set
    assign ent_addr = ENT_W'(set_reg) * ENT_W'(NUM_WAYS) + ENT_W'(way_cnt_reg);

    sacl_store #(
        .ENTRIES (ENTRIES),
        .TAG_W   (TAG_W),
        .META_W  (META_W)
    ) u_store (
        .clk     (clk),
        .addr    (ent_addr),
        .tag_we  (tag_we),
        .meta_we (meta_we),
        .wr_tag  (tag_reg),
        .wr_meta (wr_meta),
        .rd_tag  (rd_tag),
        .rd_meta (rd_meta)
    );

    sacl_way_unit #(
        .TAG_W (TAG_W),
        .WAY_W (WAY_W)
    ) u_way_unit (
        .tag_ref      (tag_reg),
        .tag_rd       (rd_tag),
        .rd_valid     (rd_meta[META_W-1]),
        .rd_rank      (rd_meta[WAY_W-1:0]),
        .rd_way       (rdw_reg),
        .hit_in       (hit_acc_reg),
        .hit_way_in   (hit_way_reg),
        .vic_way_in   (vic_way_reg),
        .vic_rank_in  (vic_rank_reg),
        .hit_out      (u_hit),
        .hit_way_out  (u_hit_way),
        .vic_way_out  (u_vic_way),
        .vic_rank_out (u_vic_rank)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_way  = (way_cnt_reg == WAY_W'(NUM_WAYS - 1));
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign way       = way_reg;

    // one restoring remainder step for non power of two set counts
    assign trial = {rem_reg, div_reg[QB-1]};

    // lru update terms for the way being written back
    assign acc_way  = hit_acc_reg ? hit_way_reg : vic_way_reg;
    assign old_rank = hit_acc_reg ? rank_reg[hit_way_reg] : vic_rank_reg;
    assign cur_rank = rank_reg[way_cnt_reg];

    always_comb
    begin
        if (way_cnt_reg == acc_way)
        begin
            new_rank = '0;
        end
        else if (cur_rank < old_rank)
        begin
            new_rank = cur_rank + WAY_W'(1);
        end
        else
        begin
            new_rank = cur_rank;
        end
    end

    // sequencer next state and memory controls
    always_comb
    begin
        state_next     = state_reg;
        set_next       = set_reg;
        way_cnt_next   = way_cnt_reg;
        tag_next       = tag_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        mod_cnt_next   = mod_cnt_reg;
        rdv_next       = 1'b0;
        rdw_next       = rdw_reg;
        hit_acc_next   = hit_acc_reg;
        hit_way_next   = hit_way_reg;
        vic_way_next   = vic_way_reg;
        vic_rank_next  = vic_rank_reg;
        out_valid_next = out_valid_reg && out_stall;
        hit_next       = hit_reg;
        way_next       = way_reg;
        tag_we         = 1'b0;
        meta_we        = 1'b0;
        wr_meta        = '0;

        if (rdv_reg)
        begin
            hit_acc_next  = u_hit;
            hit_way_next  = u_hit_way;
            vic_way_next  = u_vic_way;
            vic_rank_next = u_vic_rank;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                meta_we = 1'b1;
                wr_meta = {1'b0, WAY_W'(NUM_WAYS - 1) - way_cnt_reg};
                if (last_way)
                begin
                    way_cnt_next = '0;
                    if (set_reg == SET_W'(NUM_SETS - 1))
                    begin
                        set_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        set_next = set_reg + SET_W'(1);
                    end
                end
                else
                begin
                    way_cnt_next = way_cnt_reg + WAY_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    tag_next     = address[ADDR_BITS-1 -: TAG_W];
                    way_cnt_next = '0;
                    hit_acc_next = 1'b0;
                    if (SETS_POW2)
                    begin
                        set_next   = address[OFFSET_BITS +: SET_W];
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        rem_next     = '0;
                        div_next     = address[ADDR_BITS-1:OFFSET_BITS];
                        mod_cnt_next = QCNT_W'(QB - 1);
                        state_next   = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (trial >= (SET_W + 1)'(NUM_SETS))
                begin
                    rem_next = SET_W'(trial - (SET_W + 1)'(NUM_SETS));
                end
                else
                begin
                    rem_next = trial[SET_W-1:0];
                end
                div_next = {div_reg[QB-2:0], 1'b0};
                if (mod_cnt_reg == '0)
                begin
                    set_next   = rem_next;
                    state_next = ST_SCAN;
                end
                else
                begin
                    mod_cnt_next = mod_cnt_reg - QCNT_W'(1);
                end
            end
            ST_SCAN:
            begin
                // read of this way issues now, its compare runs next cycle
                rdv_next = 1'b1;
                rdw_next = way_cnt_reg;
                if (last_way)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    way_cnt_next = way_cnt_reg + WAY_W'(1);
                end
            end
            ST_DRAIN:
            begin
                way_cnt_next = '0;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // write back rank and valid of each way, tag only on a fill
                meta_we = 1'b1;
                wr_meta = {valid_reg[way_cnt_reg] || (way_cnt_reg == acc_way), new_rank};
                tag_we  = !hit_acc_reg && (way_cnt_reg == acc_way);
                if (last_way)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    way_cnt_next = way_cnt_reg + WAY_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = hit_acc_reg;
                    way_next       = acc_way;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            set_reg       <= '0;
            way_cnt_reg   <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            set_reg       <= set_next;
            way_cnt_reg   <= way_cnt_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        tag_reg      <= tag_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        mod_cnt_reg  <= mod_cnt_next;
        rdw_reg      <= rdw_next;
        hit_acc_reg  <= hit_acc_next;
        hit_way_reg  <= hit_way_next;
        vic_way_reg  <= vic_way_next;
        vic_rank_reg <= vic_rank_next;
        hit_reg      <= hit_next;
        way_reg      <= way_next;
    end

    // per way copy of rank and valid captured during the scan
    always_ff @(posedge clk)
    begin
        if (rdv_reg)
        begin
            rank_reg[rdw_reg]  <= rd_meta[WAY_W-1:0];
            valid_reg[rdw_reg] <= rd_meta[META_W-1];
        end
    end

`ifndef SYNTHESIS
    // a new result only comes out of the done state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared outside the done state");

    // an accepted item starts the remainder or the scan
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> (state_reg == ST_SCAN || state_reg == ST_MOD))
        else $error("accepted item did not start a lookup");

    // the last way read is still pending when the scan drains
    a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> rdv_reg)
        else $error("drain without pending read data");
`endif

endmodule
